/* hw/rtl/drop_pkg.sv */
`default_nettype none
package drop_pkg;

    localparam logic [9:0] HDR_BYTES   = 10'd240;
    localparam logic [9:0] OFFSET_MAX  = 10'd1023;
    localparam logic [9:0] XID_FIRST   = 10'd4;
    localparam logic [9:0] XID_LAST    = 10'd7;
    localparam logic [9:0] YIADDR_FIRST = 10'd16;
    localparam logic [9:0] YIADDR_LAST = 10'd19;
    localparam logic [9:0] COOKIE_FIRST = 10'd236;
    localparam logic [9:0] COOKIE_LAST = 10'd239;

    localparam logic [0:0] CFG_CLIENT_XID  = 1'd0;
    localparam logic [0:0] CFG_SERVER_PORT = 1'd1;

    localparam logic [31:0] XID_RESET  = 32'd0;
    localparam logic [15:0] PORT_RESET = 16'd67;

    localparam logic [1:0] PH_CODE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MASK     = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER   = 8'd54;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [7:0] MT_OFFER = 8'd2;
    localparam logic [7:0] MT_ACK   = 8'd5;
    localparam logic [7:0] MT_NAK   = 8'd6;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_NAK   = 2'd3;

    localparam logic [1:0] CST_WAITING = 2'd0;
    localparam logic [1:0] CST_OFFERED = 2'd1;
    localparam logic [1:0] CST_BOUND   = 2'd2;
    localparam logic [1:0] CST_FAILED  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       walk;
        logic       cap_yiaddr;
        logic       accepted;
        logic [9:0] opt_pos;
    } t_item;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  msg_kind;
        logic [1:0]  client_state;
        logic [31:0] offer_addr;
        logic [31:0] ack_addr;
        logic [31:0] server_ident;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
    } t_result;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h63;
            2'd1:    val = 8'h82;
            2'd2:    val = 8'h53;
            default: val = 8'h63;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/drop_rx_if.sv */
`default_nettype none
interface drop_rx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] udp_port;

    modport source (output valid, output data_byte, output last, output udp_port, input ready);
    modport sink (input valid, input data_byte, input last, input udp_port, output ready);
endinterface
`default_nettype wire

/* hw/rtl/drop_tx_if.sv */
`default_nettype none
interface drop_tx_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  msg_kind;
    logic [1:0]  client_state;
    logic [31:0] offer_addr;
    logic [31:0] ack_addr;
    logic [31:0] server_ident;
    logic [31:0] subnet_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_addr;

    modport source (
        output valid, output accepted, output msg_kind, output client_state,
        output offer_addr, output ack_addr, output server_ident,
        output subnet_mask, output router_addr, output dns_addr,
        input ready
    );
    modport sink (
        input valid, input accepted, input msg_kind, input client_state,
        input offer_addr, input ack_addr, input server_ident,
        input subnet_mask, input router_addr, input dns_addr,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/drop_front.sv */
`default_nettype none
module drop_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [0:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    drop_rx_if.sink            i_rx,
    output drop_pkg::t_item    o_item,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import drop_pkg::*;

    logic [31:0] r_xid;
    logic [15:0] r_sport;
    logic [9:0]  r_off;
    logic        r_hdr_ok;
    logic        r_port_ok;

    logic        xfer;
    logic        port_now;
    logic        hdr_now;
    logic        in_xid;
    logic        in_cookie;
    logic [7:0]  xid_want;

    assign i_rx.ready = i_ready;
    assign o_valid    = i_rx.valid;
    assign xfer       = i_rx.valid & i_ready;

    always_comb begin
        case (r_off[1:0])
            2'd0:    xid_want = r_xid[31:24];
            2'd1:    xid_want = r_xid[23:16];
            2'd2:    xid_want = r_xid[15:8];
            default: xid_want = r_xid[7:0];
        endcase
        in_xid    = (r_off >= XID_FIRST) && (r_off <= XID_LAST);
        in_cookie = (r_off >= COOKIE_FIRST) && (r_off <= COOKIE_LAST);
        port_now  = (r_off == '0) ? (i_rx.udp_port == r_sport) : r_port_ok;
        hdr_now   = r_hdr_ok
                  & ~(in_xid & (i_rx.data_byte != xid_want))
                  & ~(in_cookie & (i_rx.data_byte != cookie_byte(r_off[1:0])));

        o_item.data_byte  = i_rx.data_byte;
        o_item.last       = i_rx.last;
        o_item.walk       = (r_off >= HDR_BYTES) && (r_off < OFFSET_MAX) && port_now && hdr_now;
        o_item.cap_yiaddr = (r_off >= YIADDR_FIRST) && (r_off <= YIADDR_LAST);
        o_item.accepted   = port_now && hdr_now && (r_off >= COOKIE_LAST);
        o_item.opt_pos    = r_off - HDR_BYTES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xid   <= XID_RESET;
            r_sport <= PORT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CLIENT_XID) begin
                r_xid <= i_cfg_data;
            end else begin
                r_sport <= i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_hdr_ok  <= 1'b1;
            r_port_ok <= 1'b1;
        end else if (xfer) begin
            if (i_rx.last) begin
                r_off     <= '0;
                r_hdr_ok  <= 1'b1;
                r_port_ok <= 1'b1;
            end else begin
                r_off     <= (r_off >= OFFSET_MAX) ? r_off : r_off + 10'd1;
                r_hdr_ok  <= hdr_now;
                r_port_ok <= port_now;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && i_rx.last |=> r_off == '0 && r_hdr_ok && r_port_ok)
        else $error("front: packet state not cleared after last byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_item.walk |-> o_item.accepted)
        else $error("front: option byte walked in a rejected packet");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !i_rx.last && r_off < OFFSET_MAX |=> r_off == $past(r_off) + 10'd1)
        else $error("front: byte offset skipped");
endmodule
`default_nettype wire

/* hw/rtl/drop_queue.sv */
`default_nettype none
module drop_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  drop_pkg::t_item i_item,
    input  wire logic       i_push,
    output logic            o_ready,
    output drop_pkg::t_item o_item,
    output logic            o_valid,
    input  wire logic       i_pop
);
    import drop_pkg::*;

    t_item       r_slot [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        wr;
    logic        rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];
    assign wr      = i_push & o_ready;
    assign rd      = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue: occupancy out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue: pointers disagree with occupancy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr && !rd |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue: lost a transfer");
endmodule
`default_nettype wire

/* hw/rtl/drop_back.sv */
`default_nettype none
module drop_back #(
    parameter int OPTION_AREA_BYTES = 312
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  drop_pkg::t_item i_item,
    input  wire logic       i_valid,
    output logic            o_pop,
    drop_tx_if.source       o_tx
);
    import drop_pkg::*;

    localparam logic [10:0] OAB = 11'(OPTION_AREA_BYTES);

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_vidx, n_vidx;
    logic [31:0] r_shift, n_shift;
    logic        r_stop, n_stop;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_yaddr, n_yaddr;
    logic [31:0] r_offer, n_offer;
    logic [31:0] r_ack, n_ack;
    logic [31:0] r_server, n_server;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_router, n_router;
    logic [31:0] r_dns, n_dns;
    logic [1:0]  r_cst, n_cst;
    t_result     r_res, n_res;
    logic        r_ovalid, n_ovalid;

    logic [7:0]  b;
    logic [10:0] pos;
    logic [7:0]  vidx_inc;
    logic [31:0] shift_inc;
    logic [7:0]  type_byte;
    logic [1:0]  res_kind;

    assign o_pop = i_valid & (~i_item.last | ~r_ovalid | o_tx.ready);
    assign b     = i_item.data_byte;
    assign pos   = {1'b0, i_item.opt_pos};

    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_len    = r_len;
        n_vidx   = r_vidx;
        n_shift  = r_shift;
        n_stop   = r_stop;
        n_kind   = r_kind;
        n_yaddr  = r_yaddr;
        n_offer  = r_offer;
        n_ack    = r_ack;
        n_server = r_server;
        n_mask   = r_mask;
        n_router = r_router;
        n_dns    = r_dns;
        n_cst    = r_cst;
        n_res    = r_res;
        n_ovalid = o_tx.ready ? 1'b0 : r_ovalid;
        res_kind = KIND_NONE;

        vidx_inc  = r_vidx + 8'd1;
        shift_inc = (r_vidx < 8'd4) ? {r_shift[23:0], b} : r_shift;
        case (r_len)
            8'd1:    type_byte = shift_inc[7:0];
            8'd2:    type_byte = shift_inc[15:8];
            8'd3:    type_byte = shift_inc[23:16];
            default: type_byte = shift_inc[31:24];
        endcase

        if (o_pop) begin
            if (i_item.cap_yiaddr) begin
                n_yaddr = {r_yaddr[23:0], b};
            end
            if (i_item.walk && !r_stop) begin
                if (pos >= OAB) begin
                    n_stop = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_CODE: begin
                            if (b == OPT_END) begin
                                n_stop = 1'b1;
                            end else if (b != OPT_PAD) begin
                                if (pos + 11'd1 >= OAB) begin
                                    n_stop = 1'b1;
                                end else begin
                                    n_code  = b;
                                    n_phase = PH_LEN;
                                end
                            end
                        end
                        PH_LEN: begin
                            if (pos + 11'd1 + {3'b0, b} > OAB) begin
                                n_stop = 1'b1;
                            end else begin
                                n_len   = b;
                                n_vidx  = '0;
                                n_shift = '0;
                                n_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
                            end
                        end
                        PH_VALUE: begin
                            n_shift = shift_inc;
                            n_vidx  = vidx_inc;
                            if (vidx_inc == r_len) begin
                                n_phase = PH_CODE;
                                if (r_code == OPT_MSG_TYPE) begin
                                    if (type_byte == MT_OFFER) begin
                                        n_kind = KIND_OFFER;
                                    end else if (type_byte == MT_ACK) begin
                                        n_kind = KIND_ACK;
                                    end else if (type_byte == MT_NAK) begin
                                        n_kind = KIND_NAK;
                                    end else begin
                                        n_kind = KIND_NONE;
                                    end
                                end else if (r_code == OPT_SERVER && r_len == 8'd4) begin
                                    n_server = shift_inc;
                                end else if (r_code == OPT_MASK && r_len == 8'd4) begin
                                    n_mask = shift_inc;
                                end else if (r_code == OPT_ROUTER && r_len >= 8'd4) begin
                                    n_router = shift_inc;
                                end else if (r_code == OPT_DNS && r_len >= 8'd4) begin
                                    n_dns = shift_inc;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_CODE;
                        end
                    endcase
                end
            end

            if (i_item.last) begin
                res_kind = i_item.accepted ? n_kind : KIND_NONE;
                case (res_kind)
                    KIND_OFFER: begin
                        n_offer = n_yaddr;
                        n_cst   = CST_OFFERED;
                    end
                    KIND_ACK: begin
                        n_ack = n_yaddr;
                        n_cst = CST_BOUND;
                    end
                    KIND_NAK: begin
                        n_cst = CST_FAILED;
                    end
                    default: begin
                    end
                endcase
                n_res.accepted     = i_item.accepted;
                n_res.msg_kind     = res_kind;
                n_res.client_state = n_cst;
                n_res.offer_addr   = n_offer;
                n_res.ack_addr     = n_ack;
                n_res.server_ident = n_server;
                n_res.subnet_mask  = n_mask;
                n_res.router_addr  = n_router;
                n_res.dns_addr     = n_dns;
                n_ovalid           = 1'b1;
                n_phase = PH_CODE;
                n_code  = '0;
                n_len   = '0;
                n_vidx  = '0;
                n_shift = '0;
                n_stop  = 1'b0;
                n_kind  = KIND_NONE;
                n_yaddr = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CODE;
            r_code   <= '0;
            r_len    <= '0;
            r_vidx   <= '0;
            r_shift  <= '0;
            r_stop   <= 1'b0;
            r_kind   <= KIND_NONE;
            r_yaddr  <= '0;
            r_offer  <= '0;
            r_ack    <= '0;
            r_server <= '0;
            r_mask   <= '0;
            r_router <= '0;
            r_dns    <= '0;
            r_cst    <= CST_WAITING;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_len    <= n_len;
            r_vidx   <= n_vidx;
            r_shift  <= n_shift;
            r_stop   <= n_stop;
            r_kind   <= n_kind;
            r_yaddr  <= n_yaddr;
            r_offer  <= n_offer;
            r_ack    <= n_ack;
            r_server <= n_server;
            r_mask   <= n_mask;
            r_router <= n_router;
            r_dns    <= n_dns;
            r_cst    <= n_cst;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_tx.valid        = r_ovalid;
    assign o_tx.accepted     = r_res.accepted;
    assign o_tx.msg_kind     = r_res.msg_kind;
    assign o_tx.client_state = r_res.client_state;
    assign o_tx.offer_addr   = r_res.offer_addr;
    assign o_tx.ack_addr     = r_res.ack_addr;
    assign o_tx.server_ident = r_res.server_ident;
    assign o_tx.subnet_mask  = r_res.subnet_mask;
    assign o_tx.router_addr  = r_res.router_addr;
    assign o_tx.dns_addr     = r_res.dns_addr;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.msg_kind != KIND_NONE |-> r_res.accepted)
        else $error("back: message kind reported for a rejected packet");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.msg_kind == KIND_NAK |-> r_res.client_state == CST_FAILED)
        else $error("back: nak did not move client to failed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_res.msg_kind == KIND_OFFER |-> r_res.client_state == CST_OFFERED)
        else $error("back: offer did not move client to offered");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_tx.ready |-> !(o_pop && i_item.last))
        else $error("back: result overwritten while held");
endmodule
`default_nettype wire

/* hw/rtl/dhcp_reply_option_parser.sv */
`default_nettype none
// DHCP reply parser. Takes the UDP payload of a reply one byte per transfer on i_rx
// (last marks the final byte, udp_port is sampled with the first) and gives one
// result on o_tx per payload, holding the accept flag, the message kind, the client
// state and the kept addresses. The front stage checks port, transaction id and
// cookie; a two-entry queue feeds the option walker, which handles one byte per
// clock unless an earlier result is still held on o_tx; sustained rate is one byte
// per cycle under that proviso. The last byte passes through the queue, and the
// walker registers the result onto o_tx. Configuration (index 0 client_xid, 1
// server_port) may only be written while no packet is in flight.
module dhcp_reply_option_parser #(
    parameter int OPTION_AREA_BYTES = 312
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    drop_rx_if.sink          i_rx,
    drop_tx_if.source        o_tx
);
    import drop_pkg::*;

    t_item f_item;
    t_item q_item;
    logic  f_valid;
    logic  q_ready;
    logic  q_valid;
    logic  b_pop;

    drop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (i_rx),
        .o_item     (f_item),
        .o_valid    (f_valid),
        .i_ready    (q_ready)
    );

    drop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (f_item),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .o_item  (q_item),
        .o_valid (q_valid),
        .i_pop   (b_pop)
    );

    drop_back #(
        .OPTION_AREA_BYTES (OPTION_AREA_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_valid (q_valid),
        .o_pop   (b_pop),
        .o_tx    (o_tx)
    );
endmodule
`default_nettype wire
